// ----- design/cmapl_pkg.sv -----
// Shared constants, types and state encoding for the centered average peak locator.
package cmapl_pkg;

  localparam int unsigned HALF_WINDOW    = 16;
  localparam int unsigned RING_DEPTH     = 2 * HALF_WINDOW;
  localparam int unsigned MAX_RUN_LENGTH = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = SAMPLE_W;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned RING_AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned COUNT_W  = $clog2(RING_DEPTH + 1);
  localparam int unsigned RUN_W    = $clog2(MAX_RUN_LENGTH + 1);
  localparam int unsigned TOTAL_W  = MAG_W + $clog2(RING_DEPTH + 1);
  localparam int unsigned DIV_CW   = $clog2(TOTAL_W + 1);

  typedef logic [MAG_W-1:0]   mag_t;
  typedef logic [RING_AW-1:0] slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_FINIT,
    S_FCHK,
    S_FSUB,
    S_OUT
  } state_e;

endpackage

// ----- design/centered_average_peak_locator.sv -----
// Centered moving average peak locator: top level with sequencer and result register.
//
// Input channel: sample_value_i and last_sample_i move as one word when in_valid_i is
// high and in_stall_o is low. Output channel: one result word per run (peak_found_o,
// peak_position_o, peak_level_o), taken when out_valid_o is high and out_stall_i is low.
// Magnitudes live in a ring memory of 2*HALF_WINDOW entries; each sample is a read,
// a running-total update and a write-back of its ring slot.
// A sample is a read and an update step while the first window is still filling, and
// otherwise also waits for the serial divider that forms each window average.
// A sample marked last then flushes up to HALF_WINDOW - 1 tail windows, each one
// ring read when a sample leaves the window plus one divide, before the result word
// is loaded.
// The result sits in an output register, so the next run may start while it waits;
// a stalled receiver only holds the block when a second result is ready to load.
// Samples past MAX_RUN_LENGTH in one run are dropped, but a last mark still reports.
// Reset clears all run state and the output valid flag; the ring memory needs no
// clearing since every entry is written in a run before it is read.
module centered_average_peak_locator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cmapl_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                 last_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 peak_found_o,
  output logic [cmapl_pkg::POS_W-1:0]          peak_position_o,
  output logic [cmapl_pkg::LEVEL_W-1:0]        peak_level_o
);

  cmapl_pkg::state_e  state_q, state_d;
  cmapl_pkg::total_t  total_q, total_d;
  cmapl_pkg::run_t    seen_q, seen_d;
  cmapl_pkg::slot_t   wslot_q, wslot_d;
  cmapl_pkg::level_t  best_lvl_q, best_lvl_d;
  cmapl_pkg::run_t    best_idx_q, best_idx_d;
  logic               have_q, have_d;
  cmapl_pkg::mag_t    mag_q, mag_d;
  logic               last_q, last_d;
  logic               flush_q, flush_d;
  cmapl_pkg::run_t    lo_q, lo_d;
  cmapl_pkg::slot_t   lslot_q, lslot_d;
  cmapl_pkg::run_t    i_q, i_d;
  cmapl_pkg::run_t    cand_q, cand_d;

  logic                          out_valid_q;
  logic                          found_q;
  logic [cmapl_pkg::POS_W-1:0]   pos_q;
  cmapl_pkg::level_t             level_q;
  logic                          out_load;

  logic               ram_we;
  cmapl_pkg::slot_t   ram_waddr;
  cmapl_pkg::mag_t    ram_wdata;
  logic               ram_re;
  cmapl_pkg::slot_t   ram_raddr;
  cmapl_pkg::mag_t    ram_rdata;

  logic               div_start;
  cmapl_pkg::total_t  div_dividend;
  cmapl_pkg::count_t  div_divisor;
  logic               div_done;
  cmapl_pkg::level_t  div_quot;

  logic [cmapl_pkg::SAMPLE_W-1:0] raw;
  cmapl_pkg::mag_t    mag;
  cmapl_pkg::run_t    seen_inc;
  cmapl_pkg::run_t    win_start;
  cmapl_pkg::total_t  old_mag;
  cmapl_pkg::total_t  upd_total;

  cmapl_ring_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cmapl_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign raw       = sample_value_i;
  assign mag       = raw[cmapl_pkg::SAMPLE_W-1] ? (~raw + cmapl_pkg::SAMPLE_W'(1)) : raw;
  assign seen_inc  = seen_q + cmapl_pkg::RUN_W'(1);
  assign win_start = (i_q > cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW))
                     ? (i_q - cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW)) : '0;
  assign old_mag   = (seen_q >= cmapl_pkg::RUN_W'(cmapl_pkg::RING_DEPTH))
                     ? cmapl_pkg::TOTAL_W'(ram_rdata) : '0;
  assign upd_total = total_q - old_mag + cmapl_pkg::TOTAL_W'(mag_q);
  assign in_stall_o = (state_q != cmapl_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    seen_d       = seen_q;
    wslot_d      = wslot_q;
    best_lvl_d   = best_lvl_q;
    best_idx_d   = best_idx_q;
    have_d       = have_q;
    mag_d        = mag_q;
    last_d       = last_q;
    flush_d      = flush_q;
    lo_d         = lo_q;
    lslot_d      = lslot_q;
    i_d          = i_q;
    cand_d       = cand_q;
    ram_we       = 1'b0;
    ram_waddr    = wslot_q;
    ram_wdata    = mag_q;
    ram_re       = 1'b0;
    ram_raddr    = wslot_q;
    div_start    = 1'b0;
    div_dividend = total_q;
    div_divisor  = cmapl_pkg::COUNT_W'(seen_q - win_start);
    out_load     = 1'b0;

    unique case (state_q)
      cmapl_pkg::S_IDLE: begin
        if (in_valid_i) begin
          last_d = last_sample_i;
          if (seen_q < cmapl_pkg::RUN_W'(cmapl_pkg::MAX_RUN_LENGTH)) begin
            mag_d     = mag;
            ram_re    = 1'b1;
            ram_raddr = wslot_q;
            state_d   = cmapl_pkg::S_UPD;
          end else if (last_sample_i) begin
            state_d = cmapl_pkg::S_FINIT;
          end
        end
      end
      cmapl_pkg::S_UPD: begin
        total_d   = upd_total;
        ram_we    = 1'b1;
        ram_waddr = wslot_q;
        ram_wdata = mag_q;
        wslot_d   = (wslot_q == cmapl_pkg::RING_AW'(cmapl_pkg::RING_DEPTH - 1))
                    ? '0 : (wslot_q + cmapl_pkg::RING_AW'(1));
        seen_d    = seen_inc;
        if (seen_inc >= cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW)) begin
          div_start    = 1'b1;
          div_dividend = upd_total;
          div_divisor  = (seen_inc < cmapl_pkg::RUN_W'(cmapl_pkg::RING_DEPTH))
                         ? cmapl_pkg::COUNT_W'(seen_inc)
                         : cmapl_pkg::COUNT_W'(cmapl_pkg::RING_DEPTH);
          cand_d       = seen_inc - cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW);
          flush_d      = 1'b0;
          state_d      = cmapl_pkg::S_DIV;
        end else begin
          state_d = last_q ? cmapl_pkg::S_FINIT : cmapl_pkg::S_IDLE;
        end
      end
      cmapl_pkg::S_DIV: begin
        if (div_done) begin
          if (div_quot > best_lvl_q) begin
            best_lvl_d = div_quot;
            best_idx_d = cand_q;
            have_d     = 1'b1;
          end
          if (flush_q) begin
            i_d     = i_q + cmapl_pkg::RUN_W'(1);
            state_d = cmapl_pkg::S_FCHK;
          end else begin
            state_d = last_q ? cmapl_pkg::S_FINIT : cmapl_pkg::S_IDLE;
          end
        end
      end
      cmapl_pkg::S_FINIT: begin
        if (seen_q > cmapl_pkg::RUN_W'(cmapl_pkg::RING_DEPTH)) begin
          lo_d    = seen_q - cmapl_pkg::RUN_W'(cmapl_pkg::RING_DEPTH);
          lslot_d = wslot_q;
        end else begin
          lo_d    = '0;
          lslot_d = '0;
        end
        i_d     = (seen_inc > cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW))
                  ? (seen_inc - cmapl_pkg::RUN_W'(cmapl_pkg::HALF_WINDOW)) : '0;
        state_d = cmapl_pkg::S_FCHK;
      end
      cmapl_pkg::S_FCHK: begin
        if (i_q >= seen_q) begin
          state_d = cmapl_pkg::S_OUT;
        end else if (lo_q < win_start) begin
          ram_re    = 1'b1;
          ram_raddr = lslot_q;
          state_d   = cmapl_pkg::S_FSUB;
        end else begin
          div_start    = 1'b1;
          div_dividend = total_q;
          div_divisor  = cmapl_pkg::COUNT_W'(seen_q - win_start);
          cand_d       = i_q;
          flush_d      = 1'b1;
          state_d      = cmapl_pkg::S_DIV;
        end
      end
      cmapl_pkg::S_FSUB: begin
        total_d = total_q - cmapl_pkg::TOTAL_W'(ram_rdata);
        lo_d    = lo_q + cmapl_pkg::RUN_W'(1);
        lslot_d = (lslot_q == cmapl_pkg::RING_AW'(cmapl_pkg::RING_DEPTH - 1))
                  ? '0 : (lslot_q + cmapl_pkg::RING_AW'(1));
        state_d = cmapl_pkg::S_FCHK;
      end
      cmapl_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load   = 1'b1;
          total_d    = '0;
          seen_d     = '0;
          wslot_d    = '0;
          best_lvl_d = '0;
          best_idx_d = '0;
          have_d     = 1'b0;
          flush_d    = 1'b0;
          last_d     = 1'b0;
          state_d    = cmapl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cmapl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cmapl_pkg::S_IDLE;
      total_q    <= '0;
      seen_q     <= '0;
      wslot_q    <= '0;
      best_lvl_q <= '0;
      best_idx_q <= '0;
      have_q     <= 1'b0;
      last_q     <= 1'b0;
      flush_q    <= 1'b0;
      lo_q       <= '0;
      lslot_q    <= '0;
      i_q        <= '0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      seen_q     <= seen_d;
      wslot_q    <= wslot_d;
      best_lvl_q <= best_lvl_d;
      best_idx_q <= best_idx_d;
      have_q     <= have_d;
      last_q     <= last_d;
      flush_q    <= flush_d;
      lo_q       <= lo_d;
      lslot_q    <= lslot_d;
      i_q        <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    cand_q <= cand_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q <= have_q;
      pos_q   <= have_q ? best_idx_q[cmapl_pkg::POS_W-1:0] : '0;
      level_q <= have_q ? best_lvl_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign peak_found_o    = found_q;
  assign peak_position_o = pos_q;
  assign peak_level_o    = level_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == cmapl_pkg::S_DIV))
    else $error("Divider finished outside the divide state.");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= cmapl_pkg::RUN_W'(cmapl_pkg::MAX_RUN_LENGTH))
    else $error("Sample count exceeds the maximum run length.");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == cmapl_pkg::S_OUT))
    else $error("Result word appeared without a report step.");

  a_ram_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("Ring memory read and written in the same cycle.");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= cmapl_pkg::TOTAL_W'(cmapl_pkg::RING_DEPTH * 32768))
    else $error("Window total exceeds a full window of largest magnitudes.");

endmodule

// ----- design/cmapl_ring_ram.sv -----
// Synchronous ring memory of sample magnitudes with a registered read port.
module cmapl_ring_ram (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  cmapl_pkg::slot_t     waddr_i,
  input  cmapl_pkg::mag_t      wdata_i,
  input  logic                 re_i,
  input  cmapl_pkg::slot_t     raddr_i,
  output cmapl_pkg::mag_t      rdata_o
);

  cmapl_pkg::mag_t mem_q [cmapl_pkg::RING_DEPTH];
  cmapl_pkg::mag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/cmapl_divider.sv -----
// Restoring serial divider that produces one quotient bit per cycle.
module cmapl_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cmapl_pkg::total_t   dividend_i,
  input  cmapl_pkg::count_t   divisor_i,
  output logic                done_o,
  output cmapl_pkg::level_t   quotient_o
);

  cmapl_pkg::total_t              quo_q, quo_d;
  cmapl_pkg::count_t              rem_q, rem_d;
  cmapl_pkg::count_t              dvs_q, dvs_d;
  logic [cmapl_pkg::DIV_CW-1:0]   step_q, step_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [cmapl_pkg::COUNT_W:0]    rem_sh;
  logic [cmapl_pkg::COUNT_W:0]    rem_nx;
  logic                           fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[cmapl_pkg::TOTAL_W-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
    rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = cmapl_pkg::DIV_CW'(cmapl_pkg::TOTAL_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[cmapl_pkg::TOTAL_W-2:0], fits};
      rem_d  = rem_nx[cmapl_pkg::COUNT_W-1:0];
      step_d = step_q - cmapl_pkg::DIV_CW'(1);
      if (step_q == cmapl_pkg::DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[cmapl_pkg::LEVEL_W-1:0];

endmodule
